/* design/ufd_pkg.sv */
// Shared types and constants for the UART frame decoder.
// No dependencies; used by every module under design/.
`default_nettype none

package ufd_pkg;

  localparam int unsigned MAX_PAYLOAD = 128;
  // payload counter is 7 bits: lengths of 128 and above are rejected regardless
  localparam int unsigned LEN_LIMIT   = (MAX_PAYLOAD < 129) ? MAX_PAYLOAD : 129;

  localparam logic [7:0] SOF_BYTE = 8'hFE;

  typedef enum logic [2:0] {
    PH_WAIT   = 3'd0,
    PH_FN_HI  = 3'd1,
    PH_FN_LO  = 3'd2,
    PH_LEN_HI = 3'd3,
    PH_LEN_LO = 3'd4,
    PH_DATA   = 3'd5,
    PH_CHECK  = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_NONE = 3'd0,
    ST_DATA = 3'd1,
    ST_GOOD = 3'd2,
    ST_BAD  = 3'd3,
    ST_LONG = 3'd4
  } status_t;

  // one received byte held in the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } rx_beat_t;

endpackage

`default_nettype wire

/* design/ufd_in_stage.sv */
// Input register for the frame decoder: captures one rx beat per cycle while the parser keeps taking the held beat.
// Depends on ufd_pkg (rx_beat_t).
`default_nettype none

module ufd_in_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [7:0]      s_tdata,    // [7:0] rx_byte
  input  wire logic            take,       // parser consumes the held beat
  output ufd_pkg::rx_beat_t    beat
);

  logic       held_valid;
  logic [7:0] held_data;

  assign s_tready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_tready) begin
      held_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      held_data <= s_tdata;
    end
  end

  assign beat.valid = held_valid;
  assign beat.data  = held_data;

endmodule

`default_nettype wire

/* design/ufd_parser.sv */
// Frame parser: phase state, header registers, running XOR and result register.
// Depends on ufd_pkg (phase_t, status_t, rx_beat_t, constants).
`default_nettype none

module ufd_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ufd_pkg::rx_beat_t beat,
  output logic                   take,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [47:0]            m_tdata,  // [7:0] data_byte, [14:8] byte_index,
                                           // [30:15] function_code,
                                           // [46:31] payload_length, [47] zero
  output logic [2:0]             m_tuser   // [2:0] status
);

  ufd_pkg::phase_t  phase, phase_next;
  logic [15:0]      function_reg, function_reg_next;
  logic [15:0]      length_reg, length_reg_next;
  logic [6:0]       payload_count, payload_count_next;
  logic [7:0]       running_xor, running_xor_next;

  ufd_pkg::status_t status, status_next;
  logic [7:0]       data_byte, data_byte_next;
  logic [6:0]       byte_index, byte_index_next;

  logic [15:0]      len_new;
  logic [7:0]       count_inc;

  assign take = beat.valid && (!m_tvalid || m_tready);

  assign len_new   = {length_reg[15:8], beat.data};
  assign count_inc = {1'b0, payload_count} + 8'd1;

  always_comb begin
    phase_next         = phase;
    function_reg_next  = function_reg;
    length_reg_next    = length_reg;
    payload_count_next = payload_count;
    running_xor_next   = running_xor;
    status_next        = ufd_pkg::ST_NONE;
    data_byte_next     = 8'd0;
    byte_index_next    = 7'd0;
    case (phase)
      ufd_pkg::PH_WAIT: begin
        if (beat.data == ufd_pkg::SOF_BYTE) begin
          running_xor_next = ufd_pkg::SOF_BYTE;
          phase_next       = ufd_pkg::PH_FN_HI;
        end
      end
      ufd_pkg::PH_FN_HI: begin
        function_reg_next = {beat.data, 8'd0};
        running_xor_next  = running_xor ^ beat.data;
        phase_next        = ufd_pkg::PH_FN_LO;
      end
      ufd_pkg::PH_FN_LO: begin
        function_reg_next = {function_reg[15:8], beat.data};
        running_xor_next  = running_xor ^ beat.data;
        phase_next        = ufd_pkg::PH_LEN_HI;
      end
      ufd_pkg::PH_LEN_HI: begin
        length_reg_next  = {beat.data, 8'd0};
        running_xor_next = running_xor ^ beat.data;
        phase_next       = ufd_pkg::PH_LEN_LO;
      end
      ufd_pkg::PH_LEN_LO: begin
        length_reg_next  = len_new;
        running_xor_next = running_xor ^ beat.data;
        if (len_new == 16'd0) begin
          phase_next = ufd_pkg::PH_CHECK;
        end else if ({1'b0, len_new} >= 17'(ufd_pkg::LEN_LIMIT)) begin
          status_next = ufd_pkg::ST_LONG;
          phase_next  = ufd_pkg::PH_WAIT;
        end else begin
          payload_count_next = 7'd0;
          phase_next         = ufd_pkg::PH_DATA;
        end
      end
      ufd_pkg::PH_DATA: begin
        status_next        = ufd_pkg::ST_DATA;
        data_byte_next     = beat.data;
        byte_index_next    = payload_count;
        running_xor_next   = running_xor ^ beat.data;
        payload_count_next = count_inc[6:0];
        if ({8'd0, count_inc} >= length_reg) begin
          phase_next = ufd_pkg::PH_CHECK;
        end
      end
      ufd_pkg::PH_CHECK: begin
        status_next = (beat.data == running_xor) ? ufd_pkg::ST_GOOD : ufd_pkg::ST_BAD;
        phase_next  = ufd_pkg::PH_WAIT;
      end
      default: begin
        phase_next = ufd_pkg::PH_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= ufd_pkg::PH_WAIT;
      function_reg  <= 16'd0;
      length_reg    <= 16'd0;
      payload_count <= 7'd0;
      running_xor   <= 8'd0;
      m_tvalid      <= 1'b0;
    end else begin
      if (take) begin
        phase         <= phase_next;
        function_reg  <= function_reg_next;
        length_reg    <= length_reg_next;
        payload_count <= payload_count_next;
        running_xor   <= running_xor_next;
        m_tvalid      <= 1'b1;
      end else if (m_tready) begin
        m_tvalid      <= 1'b0;
      end
    end
  end

  // function_reg/length_reg only change on take, so they double as result fields
  always_ff @(posedge clk) begin
    if (take) begin
      status     <= status_next;
      data_byte  <= data_byte_next;
      byte_index <= byte_index_next;
    end
  end

  assign m_tdata = {1'b0, length_reg, function_reg, byte_index, data_byte};
  assign m_tuser = status;

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (phase == ufd_pkg::PH_WAIT) && !m_tvalid)
    else $error("parser not idle after reset");

  a_long_aborts: assert property (@(posedge clk) disable iff (rst)
    take && (status_next == ufd_pkg::ST_LONG) |=> phase == ufd_pkg::PH_WAIT)
    else $error("too-long frame not abandoned");

  a_data_len_ok: assert property (@(posedge clk) disable iff (rst)
    (phase == ufd_pkg::PH_DATA) |->
      (length_reg != 16'd0) && ({1'b0, length_reg} < 17'(ufd_pkg::LEN_LIMIT)))
    else $error("payload phase with bad length");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    (phase == ufd_pkg::PH_DATA) |-> {9'd0, payload_count} < length_reg)
    else $error("payload counter past frame length");

  a_verdict_to_wait: assert property (@(posedge clk) disable iff (rst)
    take && (phase == ufd_pkg::PH_CHECK) |=> phase == ufd_pkg::PH_WAIT)
    else $error("checksum byte did not end the frame");

endmodule

`default_nettype wire

/* design/uart_frame_decoder_core.sv */
// A byte accepted on the input sits in the input register of ufd_in_stage until the parser
// takes it; its result is registered when taken and shows on m_tdata until the handshake.
// Throughput: one byte per cycle, sustained while the result side takes a beat every cycle;
// stalls propagate back. Reset (rst, synchronous): parser waits for a start byte,
// header/XOR state is zero, no result pending.
// Depends on ufd_pkg, ufd_in_stage, ufd_parser.
`default_nettype none

module uart_frame_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // [7:0] data_byte, [14:8] byte_index,
                                      // [30:15] function_code,
                                      // [46:31] payload_length, [47] zero
  output logic [2:0]       m_tuser    // [2:0] status
);

  ufd_pkg::rx_beat_t beat;
  logic              take;

  ufd_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .take     (take),
    .beat     (beat)
  );

  ufd_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .beat     (beat),
    .take     (take),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

/* test/ufd_frame_checker.sv */
// Scoreboard for uart_frame_decoder_core: watches both stream ports, runs a parser model
// on every accepted input beat and compares each output beat with the oldest prediction.
// Depends on ufd_pkg for the phase/status enums and the payload limit.
module ufd_frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic [2:0]  m_tuser,
  output int          fail_count,
  output int          pending
);

  // 7-bit payload counter cannot index past this
  localparam int unsigned COUNTER_REACH = 128;

  typedef struct packed {
    ufd_pkg::status_t status;
    logic [7:0]       data_byte;
    logic [6:0]       byte_index;
    logic [15:0]      function_code;
    logic [15:0]      payload_length;
  } frame_result_t;

  frame_result_t frame_results_q[$];

  ufd_pkg::phase_t parse_st;
  logic [15:0]     fn_word;
  logic [15:0]     len_word;
  logic [6:0]      pay_cnt;
  logic [7:0]      run_xor;
  int              beat_no;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] result beat %0d: %s got %0h want %0h", $time, beat_no, what, got, want);
    fail_count++;
  endtask

  // one received byte through the frame parser; queues the result it must produce
  task automatic parse_rx_byte(input logic [7:0] b);
    frame_result_t r;
    logic [7:0]    nxt;
    r = '0;
    r.status = ufd_pkg::ST_NONE;
    case (parse_st)
      ufd_pkg::PH_WAIT: begin
        if (b == ufd_pkg::SOF_BYTE) begin
          run_xor  = ufd_pkg::SOF_BYTE;
          parse_st = ufd_pkg::PH_FN_HI;
        end
      end
      ufd_pkg::PH_FN_HI: begin
        fn_word  = {b, 8'h00};
        run_xor ^= b;
        parse_st = ufd_pkg::PH_FN_LO;
      end
      ufd_pkg::PH_FN_LO: begin
        fn_word[7:0] = b;
        run_xor ^= b;
        parse_st = ufd_pkg::PH_LEN_HI;
      end
      ufd_pkg::PH_LEN_HI: begin
        len_word = {b, 8'h00};
        run_xor ^= b;
        parse_st = ufd_pkg::PH_LEN_LO;
      end
      ufd_pkg::PH_LEN_LO: begin
        len_word[7:0] = b;
        run_xor ^= b;
        if (len_word == 16'd0) begin
          parse_st = ufd_pkg::PH_CHECK;
        end else if (len_word >= ufd_pkg::MAX_PAYLOAD || len_word > COUNTER_REACH) begin
          r.status = ufd_pkg::ST_LONG;
          parse_st = ufd_pkg::PH_WAIT;
        end else begin
          pay_cnt  = '0;
          parse_st = ufd_pkg::PH_DATA;
        end
      end
      ufd_pkg::PH_DATA: begin
        nxt          = {1'b0, pay_cnt} + 8'd1;
        r.status     = ufd_pkg::ST_DATA;
        r.data_byte  = b;
        r.byte_index = pay_cnt;
        run_xor     ^= b;
        pay_cnt      = nxt[6:0];
        if (nxt >= len_word) parse_st = ufd_pkg::PH_CHECK;
      end
      ufd_pkg::PH_CHECK: begin
        if (b == run_xor) r.status = ufd_pkg::ST_GOOD;
        else r.status = ufd_pkg::ST_BAD;
        parse_st = ufd_pkg::PH_WAIT;
      end
      default: parse_st = ufd_pkg::PH_WAIT;
    endcase
    r.function_code  = fn_word;
    r.payload_length = len_word;
    frame_results_q.push_back(r);
  endtask

  task automatic check_result_beat();
    frame_result_t w;
    if (frame_results_q.size() == 0) begin
      report_mismatch("beat with nothing expected, status", m_tuser, 0);
    end else begin
      w = frame_results_q.pop_front();
      if (m_tuser != w.status)            report_mismatch("status", m_tuser, w.status);
      if (m_tdata[7:0] != w.data_byte)    report_mismatch("data_byte", m_tdata[7:0], w.data_byte);
      if (m_tdata[14:8] != w.byte_index)  report_mismatch("byte_index", m_tdata[14:8], w.byte_index);
      if (m_tdata[30:15] != w.function_code)
        report_mismatch("function_code", m_tdata[30:15], w.function_code);
      if (m_tdata[46:31] != w.payload_length)
        report_mismatch("payload_length", m_tdata[46:31], w.payload_length);
      if (m_tdata[47] !== 1'b0)           report_mismatch("pad bit", m_tdata[47], 0);
    end
    beat_no++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      parse_st = ufd_pkg::PH_WAIT;
      fn_word  = '0;
      len_word = '0;
      pay_cnt  = '0;
      run_xor  = '0;
      frame_results_q.delete();
    end else begin
      // drain before predicting so a stray beat never matches this edge's prediction
      if (m_tvalid && m_tready) check_result_beat();
      if (s_tvalid && s_tready) parse_rx_byte(s_tdata);
    end
    pending <= frame_results_q.size();
  end

endmodule

/* test/tb_top.sv */
// Top of the uart_frame_decoder_core bench: clock, reset, byte stimulus with random
// source gaps and sink stalls, and the final verdict. Depends on ufd_pkg, ufd_frame_checker.
module tb_top;

  localparam int TARGET_ITEMS = 1900;
  localparam int CALM_TAIL    = 200;   // last items run with no gaps or stalls

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [2:0]  m_tuser;

  int mismatch_count;
  int results_pending;
  int items_sent    = 0;
  int src_gap_pct   = 20;
  int sink_stall_pct = 20;
  int sink_hold     = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  uart_frame_decoder_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  ufd_frame_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (mismatch_count),
    .pending    (results_pending)
  );

  // result side: random stall bursts on m_tready
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      m_tready  <= 1'b0;
    end else if (sink_stall_pct != 0 && $urandom_range(99) < sink_stall_pct) begin
      sink_hold <= $urandom_range(12, 0);
      m_tready  <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit counted);
    int gap;
    if (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
      gap = $urandom_range(13, 1);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    if (counted) items_sent++;
  endtask

  // full frame; long lengths stop after the header since no payload is awaited
  task automatic send_frame(input logic [15:0] fn, input logic [15:0] len, input bit corrupt);
    logic [7:0] sum;
    logic [7:0] pb;
    sum = ufd_pkg::SOF_BYTE ^ fn[15:8] ^ fn[7:0] ^ len[15:8] ^ len[7:0];
    send_byte(ufd_pkg::SOF_BYTE, 1'b1);
    send_byte(fn[15:8], 1'b1);
    send_byte(fn[7:0], 1'b1);
    send_byte(len[15:8], 1'b1);
    send_byte(len[7:0], 1'b1);
    if (len < ufd_pkg::LEN_LIMIT) begin
      for (int i = 0; i < len; i++) begin
        pb = 8'($urandom_range(255));
        sum ^= pb;
        send_byte(pb, 1'b1);
      end
      if (corrupt) sum ^= 8'($urandom_range(255, 1));
      send_byte(sum, 1'b1);
    end
  endtask

  initial begin
    int          pick;
    int          next_knob;
    int          n;
    logic [15:0] len;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: ignored bytes, empty frame, limit and max lengths, single-byte bad frame
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_frame(16'h0000, 16'h0000, 1'b0);
    send_frame(16'hFFFF, 16'h0080, 1'b0);
    send_frame(16'h0000, 16'hFFFF, 1'b0);
    send_frame(16'h1234, 16'h0001, 1'b1);

    next_knob = items_sent;
    while (items_sent < TARGET_ITEMS) begin
      if (items_sent >= next_knob) begin
        next_knob = items_sent + 40;
        if (items_sent >= TARGET_ITEMS - CALM_TAIL) begin
          src_gap_pct    <= 0;
          sink_stall_pct <= 0;
        end else begin
          case ($urandom_range(3))
            0: begin src_gap_pct <= 0;  sink_stall_pct <= 0;  end
            1: begin src_gap_pct <= 10; sink_stall_pct <= 10; end
            2: begin src_gap_pct <= 40; sink_stall_pct <= 40; end
            default: begin src_gap_pct <= 0; sink_stall_pct <= 50; end
          endcase
        end
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        n = $urandom_range(99);
        if (n < 60)      len = 16'($urandom_range(6));
        else if (n < 85) len = 16'($urandom_range(40, 7));
        else if (n < 95) len = 16'($urandom_range(126, 41));
        else             len = 16'd127;
        send_frame(16'($urandom_range(65535)), len, $urandom_range(99) < 15);
      end else if (pick < 78) begin
        send_frame(16'($urandom_range(65535)), 16'($urandom_range(65535, 128)), 1'b0);
      end else if (pick < 88) begin
        // line noise; a stray start byte in here opens a misaligned frame
        n = $urandom_range(6, 1);
        repeat (n) send_byte(8'($urandom_range(255)), 1'b0);
      end else begin
        // cut-off header that the next bytes continue
        send_byte(ufd_pkg::SOF_BYTE, 1'b1);
        n = $urandom_range(4, 1);
        repeat (n) send_byte(8'($urandom_range(255)), 1'b1);
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
